>>> sv/bole_pkg.sv
// bole_pkg: shared constants, request/response structs and cell control types
// for the bounded ordered list engine; no dependencies
`default_nettype none

package bole_pkg;

  localparam int CAPACITY = 128;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = ((CNT_W > 8) ? CNT_W : 8) + 1;

  localparam int GRP      = 16;
  localparam int NGRP     = (CAPACITY + GRP - 1) / GRP;
  localparam int PAD_N    = NGRP * GRP;
  localparam int GCNT_W   = $clog2(GRP + 1);

  localparam logic [2:0] OP_APPEND     = 3'd0;
  localparam logic [2:0] OP_INSERT     = 3'd1;
  localparam logic [2:0] OP_REMOVE_AT  = 3'd2;
  localparam logic [2:0] OP_REMOVE_KEY = 3'd3;
  localparam logic [2:0] OP_GET        = 3'd4;
  localparam logic [2:0] OP_FIND       = 3'd5;

  typedef struct packed {
    logic [2:0]         op;
    logic [7:0]         position;
    logic signed [31:0] key;
    logic [31:0]        value;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] found_key;
    logic [31:0]        found_value;
    logic [7:0]         count;
    logic               is_full;
    logic               is_empty;
  } rsp_t;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] value;
  } entry_t;

  typedef enum logic [2:0] {
    CM_HOLD,
    CM_INSERT,
    CM_REMOVE,
    CM_MARK_KEY,
    CM_MARK_POS,
    CM_SWAP
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t       mode;
    entry_t           ent;
    logic [IDX_W-1:0] pos0;
    logic [CNT_W-1:0] count;
    logic             phase;
  } cell_cmd_t;

  typedef struct packed {
    logic             any;
    entry_t           ent;
    logic [CNT_W-1:0] total;
  } sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SEL1,
    S_SEL2,
    S_FIN,
    S_COMPACT,
    S_RESP
  } state_t;

endpackage

`default_nettype wire

>>> sv/bole_cell.sv
// bole_cell: one list slot holding a key/value entry and a mark bit,
// shifting, marking and swapping with its neighbors; uses bole_pkg
`default_nettype none

module bole_cell (
  input  logic                         clk,
  input  logic [bole_pkg::IDX_W-1:0]   idx,
  input  bole_pkg::cell_cmd_t          cmd,
  input  bole_pkg::entry_t             left_ent,
  input  logic                         left_dead,
  input  bole_pkg::entry_t             right_ent,
  input  logic                         right_dead,
  output bole_pkg::entry_t             ent,
  output logic                         dead
);
  import bole_pkg::*;

  entry_t ent_next;
  logic   dead_next;
  logic   in_list;
  logic   lower;

  assign in_list = CNT_W'(idx) < cmd.count;
  assign lower   = (idx[0] == cmd.phase);

  always_comb begin
    ent_next  = ent;
    dead_next = dead;
    case (cmd.mode)
      CM_INSERT: begin
        if (idx == cmd.pos0) begin
          ent_next = cmd.ent;
        end else if (idx > cmd.pos0) begin
          ent_next = left_ent;
        end
      end
      CM_REMOVE: begin
        if (idx >= cmd.pos0) begin
          ent_next = right_ent;
        end
      end
      CM_MARK_KEY: dead_next = in_list && (ent.key == cmd.ent.key);
      CM_MARK_POS: dead_next = in_list && (idx == cmd.pos0);
      CM_SWAP: begin
        if (lower) begin
          if (dead && !right_dead) begin
            ent_next  = right_ent;
            dead_next = 1'b0;
          end
        end else begin
          if (left_dead && !dead) begin
            ent_next  = left_ent;
            dead_next = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    ent  <= ent_next;
    dead <= dead_next;
  end

endmodule

`default_nettype wire

>>> sv/bole_select.sv
// bole_select: two-stage registered tree picking the first marked cell and
// counting the marks; uses bole_pkg
`default_nettype none

module bole_select (
  input  logic                            clk,
  input  logic [bole_pkg::CAPACITY-1:0]   hit,
  input  bole_pkg::entry_t                ents [bole_pkg::CAPACITY],
  output bole_pkg::sel_t                  sel
);
  import bole_pkg::*;

  logic [PAD_N-1:0]  hit_pad;
  entry_t            ent_pad [PAD_N];

  logic              g_any      [NGRP];
  entry_t            g_ent      [NGRP];
  logic [GCNT_W-1:0] g_cnt      [NGRP];
  logic              g_any_next [NGRP];
  entry_t            g_ent_next [NGRP];
  logic [GCNT_W-1:0] g_cnt_next [NGRP];
  sel_t              sel_next;

  for (genvar i = 0; i < PAD_N; i++) begin : g_pad
    if (i < CAPACITY) begin : g_real
      assign hit_pad[i] = hit[i];
      assign ent_pad[i] = ents[i];
    end else begin : g_fill
      assign hit_pad[i] = 1'b0;
      assign ent_pad[i] = '0;
    end
  end

  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    always_comb begin
      g_any_next[g] = 1'b0;
      g_ent_next[g] = '0;
      g_cnt_next[g] = '0;
      for (int j = GRP - 1; j >= 0; j--) begin
        if (hit_pad[g*GRP + j]) begin
          g_any_next[g] = 1'b1;
          g_ent_next[g] = ent_pad[g*GRP + j];
        end
        g_cnt_next[g] = g_cnt_next[g] + GCNT_W'(hit_pad[g*GRP + j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < NGRP; g++) begin
      g_any[g] <= g_any_next[g];
      g_ent[g] <= g_ent_next[g];
      g_cnt[g] <= g_cnt_next[g];
    end
  end

  always_comb begin
    sel_next = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (g_any[g]) begin
        sel_next.any = 1'b1;
        sel_next.ent = g_ent[g];
      end
      sel_next.total = sel_next.total + CNT_W'(g_cnt[g]);
    end
  end

  always_ff @(posedge clk) begin
    sel <= sel_next;
  end

endmodule

`default_nettype wire

>>> sv/bounded_ordered_list_engine_core.sv
// bounded_ordered_list_engine_core: bounded ordered key/value list built as a
// row of bole_cell slots with a bole_select tree; uses bole_pkg
//
// usage
// - request channel (req_valid, req_stall, req): one operation per request;
//   req_stall is high while an earlier request is still being worked on
// - response channel (rsp_valid, rsp_stall, rsp): exactly one response per
//   request, in order, held in an output register until taken
// - states per request, accept to next accept, with the response loaded in
//   S_RESP as the engine returns to S_IDLE: append, insert, remove-at, a get
//   with a bad position and unused op codes: S_EXEC, S_RESP (one parallel
//   shift of all cells); get and find add S_SEL1, S_SEL2 and S_FIN (mark in
//   the cells, then two levels of the selection tree); remove-key adds these
//   and S_COMPACT: odd-even compaction, one phase per cycle, CAPACITY phases
// - a request is taken again as soon as the previous response has been
//   loaded, even while that response waits on rsp_stall
// - if rsp_stall holds a response, the next finished response waits in the
//   engine and req_stall stays high until the output register frees up
// - reset empties the list at once (count 0); entry storage is not cleared
// - responses report count, full and empty after the operation
`default_nettype none

module bounded_ordered_list_engine_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  bole_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output bole_pkg::rsp_t rsp
);
  import bole_pkg::*;

  state_t           state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] ph, ph_next;
  req_t             req_q;
  logic             pend_ok, pend_ok_next;
  logic [31:0]      pend_fk, pend_fk_next;
  logic [31:0]      pend_fv, pend_fv_next;
  logic             load_rsp;
  logic             accept;
  cell_cmd_t        cmd;
  sel_t             sel;

  entry_t               ents  [CAPACITY];
  logic [CAPACITY-1:0]  deads;

  logic [CMP_W-1:0] pos_w;
  logic [CMP_W-1:0] cnt_w;
  logic             not_full;
  logic [IDX_W-1:0] pos0;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;

  assign pos_w    = CMP_W'(req_q.position);
  assign cnt_w    = CMP_W'(count);
  assign not_full = count < CNT_W'(CAPACITY);
  assign pos0     = IDX_W'(req_q.position - 8'd1);

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t l_ent, r_ent;
    logic   l_dead, r_dead;
    if (i == 0) begin : g_first
      assign l_ent  = ents[i];
      assign l_dead = deads[i];
    end else begin : g_left
      assign l_ent  = ents[i-1];
      assign l_dead = deads[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign r_ent  = ents[i];
      assign r_dead = deads[i];
    end else begin : g_right
      assign r_ent  = ents[i+1];
      assign r_dead = deads[i+1];
    end
    bole_cell u_cell (
      .clk        (clk),
      .idx        (IDX_W'(i)),
      .cmd        (cmd),
      .left_ent   (l_ent),
      .left_dead  (l_dead),
      .right_ent  (r_ent),
      .right_dead (r_dead),
      .ent        (ents[i]),
      .dead       (deads[i])
    );
  end

  bole_select u_select (
    .clk  (clk),
    .hit  (deads),
    .ents (ents),
    .sel  (sel)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
    pend_ok <= pend_ok_next;
    pend_fk <= pend_fk_next;
    pend_fv <= pend_fv_next;
    ph      <= ph_next;
    if (load_rsp) begin
      rsp.ok          <= pend_ok;
      rsp.found_key   <= pend_fk;
      rsp.found_value <= pend_fv;
      rsp.count       <= 8'(count);
      rsp.is_full     <= (count == CNT_W'(CAPACITY));
      rsp.is_empty    <= (count == '0);
    end
  end

  always_comb begin
    state_next   = state;
    count_next   = count;
    ph_next      = ph;
    pend_ok_next = pend_ok;
    pend_fk_next = pend_fk;
    pend_fv_next = pend_fv;
    load_rsp     = 1'b0;
    cmd.mode     = CM_HOLD;
    cmd.ent      = '{key: req_q.key, value: req_q.value};
    cmd.pos0     = pos0;
    cmd.count    = count;
    cmd.phase    = ph[0];
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        pend_ok_next = 1'b0;
        pend_fk_next = '0;
        pend_fv_next = '0;
        state_next   = S_RESP;
        case (req_q.op)
          OP_APPEND: begin
            if (not_full) begin
              cmd.mode     = CM_INSERT;
              cmd.pos0     = IDX_W'(count);
              count_next   = count + CNT_W'(1);
              pend_ok_next = 1'b1;
            end
          end
          OP_INSERT: begin
            if (not_full && pos_w != '0 && pos_w <= cnt_w + CMP_W'(1)) begin
              cmd.mode     = CM_INSERT;
              count_next   = count + CNT_W'(1);
              pend_ok_next = 1'b1;
            end
          end
          OP_REMOVE_AT: begin
            if (pos_w != '0 && pos_w <= cnt_w) begin
              cmd.mode     = CM_REMOVE;
              count_next   = count - CNT_W'(1);
              pend_ok_next = 1'b1;
            end
          end
          OP_REMOVE_KEY, OP_FIND: begin
            cmd.mode   = CM_MARK_KEY;
            state_next = S_SEL1;
          end
          OP_GET: begin
            if (pos_w != '0 && pos_w <= cnt_w) begin
              cmd.mode   = CM_MARK_POS;
              state_next = S_SEL1;
            end
          end
          default: ;
        endcase
      end
      S_SEL1: state_next = S_SEL2;
      S_SEL2: state_next = S_FIN;
      S_FIN: begin
        pend_ok_next = sel.any;
        if (req_q.op == OP_REMOVE_KEY) begin
          count_next = count - sel.total;
          ph_next    = '0;
          state_next = S_COMPACT;
        end else begin
          pend_fk_next = sel.ent.key;
          pend_fv_next = sel.ent.value;
          state_next   = S_RESP;
        end
      end
      S_COMPACT: begin
        cmd.mode = CM_SWAP;
        ph_next  = ph + CNT_W'(1);
        if (ph == CNT_W'(CAPACITY - 1)) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (!rsp_valid || !rsp_stall) begin
          load_rsp   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_compact_op: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMPACT) |-> (req_q.op == OP_REMOVE_KEY))
    else $error("compaction outside remove-key");

  a_read_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && (req_q.op == OP_GET || req_q.op == OP_FIND)) |=> $stable(count))
    else $error("get or find changed the count");

  a_marks_in_list: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |-> (sel.total <= count))
    else $error("more marked entries than the list holds");

  a_rsp_flags: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.is_full && rsp.is_empty))
    else $error("response both full and empty");

endmodule

`default_nettype wire
